// ===== rtl/core/sfbh_pkg.sv =====
`default_nettype none
package sfbh_pkg;

	localparam int unsigned KEY_WORDS = 10;
	localparam int unsigned MIX_ROUNDS = 3;
	localparam int unsigned MIX_LINES = 6;
	localparam int unsigned FIN_LINES = 7;
	localparam int unsigned HASH_STAGES = MIX_ROUNDS * MIX_LINES + FIN_LINES;
	localparam int unsigned DIV_STAGES = 32;

	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_V4_PORTS = 3'd1;
	localparam logic [2:0] KIND_V4_ICMP  = 3'd2;
	localparam logic [2:0] KIND_V4_OTHER = 3'd3;
	localparam logic [2:0] KIND_V6       = 3'd4;

	localparam logic REG_HASH_SEED  = 1'b0;
	localparam logic REG_TABLE_SIZE = 1'b1;

	localparam logic [31:0] SEED_RESET = 32'd0;
	localparam logic [31:0] SIZE_RESET = 32'd65536;
	localparam logic [31:0] HASH_INIT = 32'hdeadbeef;
	localparam logic [31:0] LEN4_BYTES = 32'd16;
	localparam logic [31:0] LEN10_BYTES = 32'd40;
	localparam logic [15:0] FIXED_SP = 16'hfeed;
	localparam logic [15:0] FIXED_DP = 16'hbeef;

	typedef logic [KEY_WORDS-1:0][31:0] key_t;

	typedef struct packed {
		logic none;
		logic v6;
		key_t key;
	} item_t;

	typedef struct packed {
		logic valid;
		logic none;
	} ctl_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} abc_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
		rotl = (x << k) | (x >> (32 - k));
	endfunction

	function automatic abc_t mix_line(input logic [2:0] line, input abc_t x);
		abc_t y;
		y = x;
		case (line)
			3'd0: begin
				y.a = (x.a - x.c) ^ rotl(x.c, 4);
				y.c = x.c + x.b;
			end
			3'd1: begin
				y.b = (x.b - x.a) ^ rotl(x.a, 6);
				y.a = x.a + x.c;
			end
			3'd2: begin
				y.c = (x.c - x.b) ^ rotl(x.b, 8);
				y.b = x.b + x.a;
			end
			3'd3: begin
				y.a = (x.a - x.c) ^ rotl(x.c, 16);
				y.c = x.c + x.b;
			end
			3'd4: begin
				y.b = (x.b - x.a) ^ rotl(x.a, 19);
				y.a = x.a + x.c;
			end
			3'd5: begin
				y.c = (x.c - x.b) ^ rotl(x.b, 4);
				y.b = x.b + x.a;
			end
			default: y = x;
		endcase
		mix_line = y;
	endfunction

	function automatic abc_t fin_line(input logic [2:0] line, input abc_t x);
		abc_t y;
		y = x;
		case (line)
			3'd0: y.c = (x.c ^ x.b) - rotl(x.b, 14);
			3'd1: y.a = (x.a ^ x.c) - rotl(x.c, 11);
			3'd2: y.b = (x.b ^ x.a) - rotl(x.a, 25);
			3'd3: y.c = (x.c ^ x.b) - rotl(x.b, 16);
			3'd4: y.a = (x.a ^ x.c) - rotl(x.c, 4);
			3'd5: y.b = (x.b ^ x.a) - rotl(x.a, 14);
			3'd6: y.c = (x.c ^ x.b) - rotl(x.b, 24);
			default: y = x;
		endcase
		fin_line = y;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sfbh_front.sv =====
`default_nettype none
module sfbh_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [2:0]    pkt_kind,
	input  wire logic [63:0]   src_addr_hi,
	input  wire logic [63:0]   src_addr_lo,
	input  wire logic [63:0]   dst_addr_hi,
	input  wire logic [63:0]   dst_addr_lo,
	input  wire logic [15:0]   src_port,
	input  wire logic [15:0]   dst_port,
	input  wire logic [7:0]    protocol,
	input  wire logic [15:0]   tunnel_depth,
	output logic               valid_s1,
	output sfbh_pkg::item_t    item_s1
);
	import sfbh_pkg::*;

	logic [127:0] src_full;
	logic [127:0] dst_full;
	logic [127:0] first6;
	logic [127:0] second6;
	logic [31:0]  first4;
	logic [31:0]  second4;
	logic [31:0]  port_w;
	logic [31:0]  proto_w;
	logic         is_v4;
	item_t        item_c;

	always_comb begin
		src_full = {src_addr_hi, src_addr_lo};
		dst_full = {dst_addr_hi, dst_addr_lo};
		first6   = (src_full > dst_full) ? src_full : dst_full;
		second6  = (src_full > dst_full) ? dst_full : src_full;
		first4   = (src_addr_hi[63:32] > dst_addr_hi[63:32]) ? src_addr_hi[63:32]
		                                                     : dst_addr_hi[63:32];
		second4  = (src_addr_hi[63:32] > dst_addr_hi[63:32]) ? dst_addr_hi[63:32]
		                                                     : src_addr_hi[63:32];
		port_w   = (src_port > dst_port) ? {dst_port, src_port} : {src_port, dst_port};
		proto_w  = {tunnel_depth, 8'd0, protocol};
		is_v4    = pkt_kind inside {KIND_V4_PORTS, KIND_V4_ICMP, KIND_V4_OTHER};
		item_c   = '0;
		item_c.none = !(is_v4 || pkt_kind == KIND_V6);
		item_c.v6   = (pkt_kind == KIND_V6);
		if (item_c.v6) begin
			for (int i = 0; i < 4; i++) begin
				item_c.key[i]     = first6[127 - 32*i -: 32];
				item_c.key[4 + i] = second6[127 - 32*i -: 32];
			end
			item_c.key[8] = port_w;
		end else begin
			item_c.key[0] = first4;
			item_c.key[1] = second4;
			item_c.key[2] = (pkt_kind == KIND_V4_OTHER) ? {FIXED_DP, FIXED_SP} : port_w;
		end
		item_c.key[9] = proto_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sfbh_queue.sv =====
`default_nettype none
module sfbh_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sfbh_pkg::item_t  push_item,
	output logic                  almost_full,
	output logic                  pop_valid,
	output sfbh_pkg::item_t       pop_item
);
	import sfbh_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	always_comb begin
		pop         = (count_q != '0);
		pop_valid   = pop;
		pop_item    = mem_q[rd_ptr_q];
		almost_full = (count_q >= CW'(DEPTH - 1));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sfbh_hash.sv =====
`default_nettype none
module sfbh_hash (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire sfbh_pkg::item_t  in_item,
	input  wire logic [31:0]      seed,
	output sfbh_pkg::ctl_t        out_ctl,
	output logic [31:0]           out_hash
);
	import sfbh_pkg::*;

	ctl_t ctl_s [HASH_STAGES + 1];
	logic v6_s  [HASH_STAGES + 1];
	key_t key_s [HASH_STAGES + 1];
	abc_t abc_s [HASH_STAGES + 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0].valid <= in_valid;
			ctl_s[0].none  <= in_item.none;
		end
	end

	always_ff @(posedge clk) begin
		v6_s[0]  <= in_item.v6;
		key_s[0] <= in_item.key;
		abc_s[0].a <= HASH_INIT + seed + (in_item.v6 ? LEN10_BYTES : LEN4_BYTES);
		abc_s[0].b <= HASH_INIT + seed + (in_item.v6 ? LEN10_BYTES : LEN4_BYTES);
		abc_s[0].c <= HASH_INIT + seed + (in_item.v6 ? LEN10_BYTES : LEN4_BYTES);
	end

	for (genvar s = 1; s <= HASH_STAGES; s++) begin : g_stage
		localparam int unsigned IDX = s - 1;
		localparam bit IS_MIX = (IDX < MIX_ROUNDS * MIX_LINES);
		localparam int unsigned ROUND = IDX / MIX_LINES;
		localparam int unsigned LINE = IS_MIX ? (IDX % MIX_LINES)
		                                      : (IDX - MIX_ROUNDS * MIX_LINES);
		localparam int unsigned KB = IS_MIX ? 3 * ROUND : 0;

		abc_t pre;
		abc_t post;

		always_comb begin
			pre = abc_s[s-1];
			if (IS_MIX) begin
				if (LINE == 0) begin
					pre.a = pre.a + key_s[s-1][KB];
					pre.b = pre.b + key_s[s-1][KB + 1];
					pre.c = pre.c + key_s[s-1][KB + 2];
				end
				post = mix_line(3'(LINE), pre);
				if (!(ROUND == 0 || v6_s[s-1])) begin
					post = abc_s[s-1];
				end
			end else begin
				if (LINE == 0) begin
					pre.a = pre.a + key_s[s-1][KEY_WORDS - 1];
				end
				post = fin_line(3'(LINE), pre);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[s] <= '0;
			end else begin
				ctl_s[s] <= ctl_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			v6_s[s]  <= v6_s[s-1];
			key_s[s] <= key_s[s-1];
			abc_s[s] <= post;
		end
	end

	assign out_ctl  = ctl_s[HASH_STAGES];
	assign out_hash = abc_s[HASH_STAGES].c;

endmodule
`default_nettype wire

// ===== rtl/core/sfbh_mod.sv =====
`default_nettype none
module sfbh_mod (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sfbh_pkg::ctl_t   in_ctl,
	input  wire logic [31:0]      in_hash,
	input  wire logic [31:0]      divisor,
	output sfbh_pkg::ctl_t        out_ctl,
	output logic [31:0]           out_hash,
	output logic [31:0]           out_rem
);
	import sfbh_pkg::*;

	ctl_t        ctl_s  [DIV_STAGES + 1];
	logic [31:0] hash_s [DIV_STAGES + 1];
	logic [31:0] rem_s  [DIV_STAGES + 1];

	assign ctl_s[0]  = in_ctl;
	assign hash_s[0] = in_hash;
	assign rem_s[0]  = '0;

	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_bit
		localparam int unsigned B = DIV_STAGES - j;

		logic [32:0] trial;
		logic [32:0] diff;

		always_comb begin
			trial = {rem_s[j-1], hash_s[j-1][B]};
			diff  = trial - {1'b0, divisor};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			hash_s[j] <= hash_s[j-1];
			rem_s[j]  <= (trial >= {1'b0, divisor}) ? diff[31:0] : trial[31:0];
		end
	end

	assign out_ctl  = ctl_s[DIV_STAGES];
	assign out_hash = hash_s[DIV_STAGES];
	assign out_rem  = rem_s[DIV_STAGES];

endmodule
`default_nettype wire

// ===== rtl/core/symmetric_flow_bucket_hash_top.sv =====
// Throughput: one item per cycle while busy is low; each accepted item strobes done.
// A 26-stage lookup3 pipeline (seed setup, then the mix and final steps) and a 32-stage modulo
// pipeline, one quotient bit per stage, carry the work; done and bucket are registered.
// Reset clears all control state, sets hash_seed to 0 and table_size to 65536.
// Results cannot stall, the queue drains every cycle, so busy stays low when QUEUE_DEPTH >= 3.
`default_nettype none
module symmetric_flow_bucket_hash_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  pkt_kind,
	input  wire logic [63:0] src_addr_hi,
	input  wire logic [63:0] src_addr_lo,
	input  wire logic [63:0] dst_addr_hi,
	input  wire logic [63:0] dst_addr_lo,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [7:0]  protocol,
	input  wire logic [15:0] tunnel_depth,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [31:0]      bucket,
	output logic [31:0]      raw_hash
);
	import sfbh_pkg::*;

	logic [31:0] hash_seed_q;
	logic [31:0] table_size_q;
	logic        accept;
	logic        front_valid_s1;
	item_t       front_item_s1;
	logic        almost_full;
	logic        q_valid;
	item_t       q_item;
	ctl_t        hash_ctl;
	logic [31:0] hash_val;
	ctl_t        mod_ctl;
	logic [31:0] mod_hash;
	logic [31:0] mod_rem;
	logic        done_q;
	logic [31:0] bucket_q;
	logic [31:0] raw_hash_q;

	assign accept    = start && !busy;
	assign busy      = almost_full;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q  <= SEED_RESET;
			table_size_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HASH_SEED:  hash_seed_q <= cfg_data;
				REG_TABLE_SIZE: table_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sfbh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pkt_kind     (pkt_kind),
		.src_addr_hi  (src_addr_hi),
		.src_addr_lo  (src_addr_lo),
		.dst_addr_hi  (dst_addr_hi),
		.dst_addr_lo  (dst_addr_lo),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.protocol     (protocol),
		.tunnel_depth (tunnel_depth),
		.valid_s1     (front_valid_s1),
		.item_s1      (front_item_s1)
	);

	sfbh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (front_valid_s1),
		.push_item   (front_item_s1),
		.almost_full (almost_full),
		.pop_valid   (q_valid),
		.pop_item    (q_item)
	);

	sfbh_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_item  (q_item),
		.seed     (hash_seed_q),
		.out_ctl  (hash_ctl),
		.out_hash (hash_val)
	);

	sfbh_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (hash_ctl),
		.in_hash  (hash_val),
		.divisor  (table_size_q),
		.out_ctl  (mod_ctl),
		.out_hash (mod_hash),
		.out_rem  (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= mod_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		raw_hash_q <= mod_ctl.none ? '0 : mod_hash;
		bucket_q   <= (mod_ctl.none || table_size_q == '0) ? '0 : mod_rem;
	end

	assign done     = done_q;
	assign bucket   = bucket_q;
	assign raw_hash = raw_hash_q;

endmodule
`default_nettype wire
